FILE: rtl/core/psm_pkg.sv
package psm_pkg;

  localparam int ID_W       = 14;
  localparam int EV_TIME_W  = 20;
  localparam int MAX_ADMIT  = 16;
  localparam int ADM_W      = $clog2(MAX_ADMIT + 1);
  localparam logic [7:0] QUANTUM_RST = 8'd5;

  typedef struct packed {
    logic            action;
    logic [ID_W-1:0] job_id;
    logic [ID_W-1:0] burst_time;
    logic [ID_W-1:0] arrival_time;
    logic [ID_W-1:0] job_priority;
  } job_word_t;

  typedef struct packed {
    logic [2:0]           event_res;
    logic [ID_W-1:0]      event_job;
    logic [EV_TIME_W-1:0] event_time;
    logic                 last;
  } event_word_t;

  // one queue entry; arr_or_used is arrival while pending, ticks used once ready
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] burst;
    logic [ID_W-1:0] arr_or_used;
    logic [ID_W-1:0] prio;
  } slot_t;

  typedef enum logic [2:0] {
    EV_ACCEPTED, EV_PEND_FULL, EV_ADMITTED, EV_DISPATCHED,
    EV_TERMINATED, EV_REQUEUED, EV_IDLE_TICK, EV_ALL_EMPTY
  } ev_code_t;

  typedef enum logic [1:0] {POL_RR, POL_FCFS, POL_SJF, POL_PRIO} policy_t;

  typedef enum logic [0:0] {CFG_POLICY, CFG_QUANTUM} cfg_reg_t;

  typedef enum logic [0:0] {ACT_SUBMIT, ACT_ROUND} action_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_SUBMIT, OP_ROUND_INIT, OP_PRD, OP_ADMIT, OP_KEEP,
    OP_PEND_SET, OP_IDLE_TICK, OP_RRD, OP_SCMP, OP_SEL_RD, OP_JOB_LAT,
    OP_SH_RD, OP_SH_WR, OP_RDEC, OP_RUN, OP_REQUEUE
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUB, ST_RSTART, ST_A_RD, ST_A_CHK, ST_A_END, ST_IDLE_T,
    ST_S_RD, ST_S_CHK, ST_D_RD, ST_D_LAT, ST_SH_CHK, ST_SH_WR, ST_D_EMIT,
    ST_D_RUN, ST_D_FIN
  } state_t;

  typedef struct packed {
    op_t      op;
    logic     emit;
    ev_code_t code;
    logic     last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic    out_free;
    logic    p_empty;
    logic    p_full;
    logic    r_empty;
    logic    adm_ok;
    logic    i_last_p;
    logic    i_last_r;
    logic    sh_more;
    logic    job_term;
    policy_t policy;
  } dp_status_t;

endpackage

FILE: rtl/core/process_scheduler_multi_policy.sv
// Multi-policy job scheduler. A submit word queues a job in a FIFO pending
// queue and answers accepted or pending full; a round word admits due jobs
// (up to 16 per round, while ready slots are free) and dispatches one job by
// round robin, first come first served, shortest burst or lowest priority
// value, ties to the earliest queued job, reporting every event with the
// simulated time. One item is in work at a time. A round walks every pending
// entry with a read and a check on the single pending memory port, and
// shifts down the ready entries behind the removed one; shortest burst and
// priority first search the ready entries for the minimum. Each event waits
// for the output register, so a stalled consumer holds the scheduler.
// Configuration is taken at any time but meant only while idle.
module process_scheduler_multi_policy #(
  parameter int PENDING_DEPTH = 16,
  parameter int READY_SLOTS   = 16,
  parameter int TIME_BITS     = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  // job channel
  input  logic                  job_valid,
  output logic                  job_stall,
  input  psm_pkg::job_word_t    job_word,
  // event channel
  output logic                  event_valid,
  input  logic                  event_stall,
  output psm_pkg::event_word_t  event_word,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  psm_pkg::cfg_reg_t     cfg_index,
  input  logic [7:0]            cfg_data
);
  import psm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // registers accept a write every cycle
  assign cfg_ready = 1'b1;

  psm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .action    (job_word.action),
    .status    (status),
    .job_stall (job_stall),
    .cmd       (cmd)
  );

  psm_dp #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .READY_SLOTS   (READY_SLOTS),
    .TIME_BITS     (TIME_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .job_word    (job_word),
    .cmd         (cmd),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .event_stall (event_stall),
    .event_valid (event_valid),
    .event_word  (event_word),
    .status      (status)
  );

endmodule

FILE: rtl/core/psm_ctrl.sv
module psm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  input  logic                 action,
  input  psm_pkg::dp_status_t  status,
  output logic                 job_stall,
  output psm_pkg::ctrl_cmd_t   cmd
);
  import psm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.emit   = 1'b0;
    cmd.code   = EV_ACCEPTED;
    cmd.last   = 1'b0;
    job_stall  = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          cmd.op     = OP_LATCH;
          state_next = (action == ACT_ROUND) ? ST_RSTART : ST_SUB;
        end
      end
      ST_SUB: begin
        cmd.op     = OP_SUBMIT;
        cmd.emit   = 1'b1;
        cmd.code   = status.p_full ? EV_PEND_FULL : EV_ACCEPTED;
        cmd.last   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RSTART: begin
        if (status.p_empty && status.r_empty) begin
          cmd.emit   = 1'b1;
          cmd.code   = EV_ALL_EMPTY;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.op     = OP_ROUND_INIT;
          state_next = status.p_empty ? ST_A_END : ST_A_RD;
        end
      end
      ST_A_RD: begin
        cmd.op     = OP_PRD;
        state_next = ST_A_CHK;
      end
      ST_A_CHK: begin
        if (status.adm_ok) begin
          cmd.op   = OP_ADMIT;
          cmd.emit = 1'b1;
          cmd.code = EV_ADMITTED;
        end else begin
          cmd.op   = OP_KEEP;
        end
        state_next = status.i_last_p ? ST_A_END : ST_A_RD;
      end
      ST_A_END: begin
        cmd.op = OP_PEND_SET;
        if (status.r_empty) begin
          state_next = ST_IDLE_T;
        end else if (status.policy == POL_SJF || status.policy == POL_PRIO) begin
          state_next = ST_S_RD;
        end else begin
          state_next = ST_D_RD;
        end
      end
      ST_IDLE_T: begin
        cmd.op     = OP_IDLE_TICK;
        cmd.emit   = 1'b1;
        cmd.code   = EV_IDLE_TICK;
        cmd.last   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_S_RD: begin
        cmd.op     = OP_RRD;
        state_next = ST_S_CHK;
      end
      ST_S_CHK: begin
        cmd.op     = OP_SCMP;
        state_next = status.i_last_r ? ST_D_RD : ST_S_RD;
      end
      ST_D_RD: begin
        cmd.op     = OP_SEL_RD;
        state_next = ST_D_LAT;
      end
      ST_D_LAT: begin
        cmd.op     = OP_JOB_LAT;
        state_next = ST_SH_CHK;
      end
      ST_SH_CHK: begin
        if (status.sh_more) begin
          cmd.op     = OP_SH_RD;
          state_next = ST_SH_WR;
        end else begin
          cmd.op     = OP_RDEC;
          state_next = ST_D_EMIT;
        end
      end
      ST_SH_WR: begin
        cmd.op     = OP_SH_WR;
        state_next = ST_SH_CHK;
      end
      ST_D_EMIT: begin
        cmd.emit   = 1'b1;
        cmd.code   = EV_DISPATCHED;
        state_next = ST_D_RUN;
      end
      ST_D_RUN: begin
        cmd.op     = OP_RUN;
        state_next = ST_D_FIN;
      end
      ST_D_FIN: begin
        cmd.emit = 1'b1;
        cmd.last = 1'b1;
        if (status.policy == POL_RR && !status.job_term) begin
          cmd.op   = OP_REQUEUE;
          cmd.code = EV_REQUEUED;
        end else begin
          cmd.code = EV_TERMINATED;
        end
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // hold while the output register is still occupied
    if (cmd.emit && !status.out_free) begin
      cmd.op     = OP_NONE;
      cmd.emit   = 1'b0;
      state_next = state;
    end
  end

endmodule

FILE: rtl/core/psm_dp.sv
module psm_dp #(
  parameter int PENDING_DEPTH = 16,
  parameter int READY_SLOTS   = 16,
  parameter int TIME_BITS     = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  psm_pkg::job_word_t    job_word,
  input  psm_pkg::ctrl_cmd_t    cmd,
  input  logic                  cfg_valid,
  input  psm_pkg::cfg_reg_t     cfg_index,
  input  logic [7:0]            cfg_data,
  input  logic                  event_stall,
  output logic                  event_valid,
  output psm_pkg::event_word_t  event_word,
  output psm_pkg::dp_status_t   status
);
  import psm_pkg::*;

  localparam int PIW = $clog2(PENDING_DEPTH);
  localparam int PCW = $clog2(PENDING_DEPTH + 1);
  localparam int RIW = $clog2(READY_SLOTS);
  localparam int RCW = $clog2(READY_SLOTS + 1);
  localparam int IW  = (PCW > RCW) ? PCW : RCW;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  slot_t pmem [PENDING_DEPTH];
  slot_t rmem [READY_SLOTS];
  slot_t prd, rrd, job;
  job_word_t jw;

  logic [PCW-1:0] pcount, keep;
  logic [RCW-1:0] rcount;
  logic [IW-1:0]  idx, idx_inc;
  logic [RIW-1:0] sel, k;
  logic [RCW-1:0] k_inc;
  logic [ADM_W-1:0] admitted;
  logic [ID_W-1:0]  best, key;
  logic [TIME_BITS-1:0] sim_time, t_new;
  policy_t    policy;
  logic [7:0] quantum;

  logic           p_we, p_re, r_we, r_re;
  logic [PIW-1:0] p_waddr, p_raddr;
  logic [RIW-1:0] r_waddr, r_raddr;
  slot_t          p_wdata, r_wdata;

  logic [7:0]      q;
  logic [ID_W-1:0] rem_rr, rem_full, run, d;
  logic [TIME_BITS:0] sum;
  logic [TIME_BITS+EV_TIME_W-1:0] time_ext;
  logic [ID_W-1:0] ev_job;

  assign idx_inc = idx + 1'b1;
  assign k_inc   = RCW'(k) + 1'b1;
  assign key     = (policy == POL_SJF) ? rrd.burst : rrd.prio;

  // run length of the dispatched job
  assign q        = (quantum == 8'd0) ? 8'd1 : quantum;
  assign rem_rr   = (job.arr_or_used < job.burst) ? job.burst - job.arr_or_used : ID_W'(1);
  assign rem_full = (job.arr_or_used < job.burst) ? job.burst - job.arr_or_used : '0;
  assign run      = (rem_rr < ID_W'(q)) ? rem_rr : ID_W'(q);

  always_comb begin
    if (cmd.op == OP_IDLE_TICK) begin
      d = ID_W'(1);
    end else if (policy == POL_RR) begin
      d = run;
    end else begin
      d = rem_full;
    end
  end

  assign sum   = {1'b0, sim_time} + (TIME_BITS + 1)'(d);
  assign t_new = (sum >= {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_BITS-1:0];

  always_comb begin
    p_we    = 1'b0;
    p_re    = 1'b0;
    r_we    = 1'b0;
    r_re    = 1'b0;
    p_waddr = keep[PIW-1:0];
    p_raddr = idx[PIW-1:0];
    r_waddr = rcount[RIW-1:0];
    r_raddr = idx[RIW-1:0];
    p_wdata = prd;
    r_wdata = job;
    case (cmd.op)
      OP_SUBMIT: begin
        p_we    = !status.p_full;
        p_waddr = pcount[PIW-1:0];
        p_wdata = '{id: jw.job_id, burst: jw.burst_time,
                    arr_or_used: jw.arrival_time, prio: jw.job_priority};
      end
      OP_PRD:  p_re = 1'b1;
      OP_KEEP: p_we = 1'b1;
      OP_ADMIT: begin
        r_we    = 1'b1;
        r_wdata = '{id: prd.id, burst: prd.burst, arr_or_used: '0, prio: prd.prio};
      end
      OP_RRD: r_re = 1'b1;
      OP_SEL_RD: begin
        r_re    = 1'b1;
        r_raddr = sel;
      end
      OP_SH_RD: begin
        r_re    = 1'b1;
        r_raddr = k_inc[RIW-1:0];
      end
      OP_SH_WR: begin
        r_we    = 1'b1;
        r_waddr = k;
        r_wdata = rrd;
      end
      OP_REQUEUE: r_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_we) pmem[p_waddr] <= p_wdata;
    if (p_re) prd <= pmem[p_raddr];
    if (r_we) rmem[r_waddr] <= r_wdata;
    if (r_re) rrd <= rmem[r_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcount   <= '0;
      rcount   <= '0;
      sim_time <= '0;
      policy   <= POL_RR;
      quantum  <= QUANTUM_RST;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_POLICY:  policy  <= policy_t'(cfg_data[1:0]);
          CFG_QUANTUM: quantum <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_SUBMIT:    if (!status.p_full) pcount <= pcount + 1'b1;
        OP_ADMIT:     rcount <= rcount + 1'b1;
        OP_PEND_SET:  pcount <= keep;
        OP_IDLE_TICK: sim_time <= t_new;
        OP_RDEC:      rcount <= rcount - 1'b1;
        OP_RUN:       sim_time <= t_new;
        OP_REQUEUE:   rcount <= rcount + 1'b1;
        default: ;
      endcase
    end
  end

  // scan and job registers, no reset needed
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: jw <= job_word;
      OP_ROUND_INIT: begin
        idx      <= '0;
        keep     <= '0;
        admitted <= '0;
      end
      OP_ADMIT: begin
        admitted <= admitted + 1'b1;
        idx      <= idx_inc;
      end
      OP_KEEP: begin
        keep <= keep + 1'b1;
        idx  <= idx_inc;
      end
      OP_PEND_SET: begin
        idx  <= '0;
        sel  <= '0;
        best <= '1;
      end
      OP_SCMP: begin
        if (key < best) begin
          best <= key;
          sel  <= idx[RIW-1:0];
        end
        idx <= idx_inc;
      end
      OP_SEL_RD:  k <= sel;
      OP_JOB_LAT: job <= rrd;
      OP_SH_WR:   k <= k_inc[RIW-1:0];
      OP_RUN:     if (policy == POL_RR) job.arr_or_used <= job.arr_or_used + run;
      default: ;
    endcase
  end

  always_comb begin
    case (cmd.code)
      EV_ACCEPTED, EV_PEND_FULL:               ev_job = jw.job_id;
      EV_ADMITTED:                             ev_job = prd.id;
      EV_DISPATCHED, EV_TERMINATED, EV_REQUEUED: ev_job = job.id;
      default:                                 ev_job = '0;
    endcase
  end

  assign time_ext = {{EV_TIME_W{1'b0}}, sim_time};

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (cmd.emit) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      event_word.event_res  <= cmd.code;
      event_word.event_job  <= ev_job;
      event_word.event_time <= time_ext[EV_TIME_W-1:0];
      event_word.last       <= cmd.last;
    end
  end

  always_comb begin
    status.out_free = !event_valid || !event_stall;
    status.p_empty  = (pcount == '0);
    status.p_full   = (pcount == PCW'(PENDING_DEPTH));
    status.r_empty  = (rcount == '0);
    status.adm_ok   = (TIME_BITS'(prd.arr_or_used) <= sim_time)
                      && (rcount != RCW'(READY_SLOTS))
                      && (admitted != ADM_W'(MAX_ADMIT));
    status.i_last_p = (idx_inc == IW'(pcount));
    status.i_last_r = (idx_inc == IW'(rcount));
    status.sh_more  = (k_inc < rcount);
    status.job_term = (job.arr_or_used >= job.burst);
    status.policy   = policy;
  end

endmodule
